// ===== rtl/wmec_pkg.sv =====
// Package for the wheel move controller: opcodes, headings, field widths and
// the structs passed between the wheel units, the result queue and the top level.
// No dependencies.
package wmec_pkg;

  // Field widths fixed by the item format.
  localparam int OPCODE_W  = 2;
  localparam int DIR_W     = 3;
  localparam int GOAL_W    = 31;
  localparam int POS_OUT_W = 32;

  // Input item kinds. The unused code is a no-op and falls to a default arm.
  typedef enum logic [OPCODE_W-1:0] {
    OP_MOVE = 2'd0,
    OP_EDGE = 2'd1,
    OP_TICK = 2'd2
  } opcode_e;

  // Heading codes. Codes above DIR_CCW behave like a stop.
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 3'd0,
    DIR_FWD  = 3'd1,
    DIR_BACK = 3'd2,
    DIR_CW   = 3'd3,
    DIR_CCW  = 3'd4
  } direction_e;

  // Command fields shared by every wheel unit.
  typedef struct packed {
    opcode_e           opcode;
    logic [DIR_W-1:0]  direction;
    logic [GOAL_W-1:0] pulse_target;
    logic              phase_b;
  } wheel_cmd_t;

  // Per-wheel view of the state after the current word.
  typedef struct packed {
    logic                        in1;
    logic                        in2;
    logic                        busy;
    logic                        reached;
    logic signed [POS_OUT_W-1:0] position;
  } wheel_stat_t;

  // One result word.
  typedef struct packed {
    logic                        right_in1;
    logic                        right_in2;
    logic                        left_in1;
    logic                        left_in2;
    logic                        right_busy;
    logic                        left_busy;
    logic signed [POS_OUT_W-1:0] right_position;
    logic signed [POS_OUT_W-1:0] left_position;
    logic                        right_reached;
    logic                        left_reached;
  } result_t;

  // True for headings that count the position up.
  function automatic logic heads_plus(logic [DIR_W-1:0] dir);
    return (dir == DIR_FWD) || (dir == DIR_CW);
  endfunction

  // True for headings that count the position down.
  function automatic logic heads_minus(logic [DIR_W-1:0] dir);
    return (dir == DIR_BACK) || (dir == DIR_CCW);
  endfunction

endpackage

// ===== rtl/wmec_in_if.sv =====
// Input channel of the wheel move controller: valid/ready and the command word.
// Depends on wmec_pkg for the field widths.
interface wmec_in_if
  import wmec_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                wheel;
  logic [DIR_W-1:0]    direction;
  logic [GOAL_W-1:0]   pulse_target;
  logic                phase_b;

  modport source (output valid, opcode, wheel, direction, pulse_target, phase_b,
                  input ready);
  modport sink   (input valid, opcode, wheel, direction, pulse_target, phase_b,
                  output ready);
endinterface

// ===== rtl/wmec_out_if.sv =====
// Output channel of the wheel move controller: valid/ready and the result word.
// Depends on wmec_pkg for the field widths.
interface wmec_out_if
  import wmec_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic                        right_in1;
  logic                        right_in2;
  logic                        left_in1;
  logic                        left_in2;
  logic                        right_busy;
  logic                        left_busy;
  logic signed [POS_OUT_W-1:0] right_position;
  logic signed [POS_OUT_W-1:0] left_position;
  logic                        right_reached;
  logic                        left_reached;

  modport source (output valid, right_in1, right_in2, left_in1, left_in2, right_busy,
                  left_busy, right_position, left_position, right_reached,
                  left_reached, input ready);
  modport sink   (input valid, right_in1, right_in2, left_in1, left_in2, right_busy,
                  left_busy, right_position, left_position, right_reached,
                  left_reached, output ready);
endinterface

// ===== rtl/wmec_wheel.sv =====
// One wheel: position counter, pulse goal, heading and drive flag, with the
// target check. Depends on wmec_pkg.
module wmec_wheel
  import wmec_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        sel_i,
  input  wheel_cmd_t  cmd_i,
  output wheel_stat_t stat_o
);

  logic [POSITION_BITS-1:0] pos_q, pos_d, step_pos, mag;
  logic [GOAL_W-1:0]        goal_q, goal_d;
  logic [DIR_W-1:0]         head_q, head_d;
  logic                     driven_q, driven_d;
  logic                     step_en, step_dn, hit, reached;

  // Next state for the current word.
  always_comb begin
    pos_d    = pos_q;
    goal_d   = goal_q;
    head_d   = head_q;
    driven_d = driven_q;
    reached  = 1'b0;
    step_en  = 1'b0;
    step_dn  = 1'b0;

    unique case (cmd_i.opcode)
      OP_MOVE: begin
        if (sel_i) begin
          head_d   = cmd_i.direction;
          goal_d   = cmd_i.pulse_target;
          pos_d    = '0;
          driven_d = (cmd_i.pulse_target != '0) &&
                     (heads_plus(cmd_i.direction) || heads_minus(cmd_i.direction));
        end
      end
      OP_EDGE: begin
        if (sel_i) begin
          step_en = 1'b1;
          step_dn = cmd_i.phase_b;
        end
      end
      OP_TICK: begin
        if (driven_q && heads_plus(head_q)) begin
          step_en = 1'b1;
        end else if (driven_q && heads_minus(head_q)) begin
          step_en = 1'b1;
          step_dn = 1'b1;
        end
      end
      default: ;
    endcase

    // One step up or down, then the magnitude compare against the goal.
    step_pos = step_dn ? (pos_q - POSITION_BITS'(1)) : (pos_q + POSITION_BITS'(1));
    mag      = step_pos[POSITION_BITS-1] ? (~step_pos + POSITION_BITS'(1)) : step_pos;
    hit      = (goal_q != '0) && (POS_OUT_W'(mag) >= {1'b0, goal_q});

    if (step_en) begin
      pos_d = step_pos;
      if (hit) begin
        driven_d = 1'b0;
        reached  = driven_q;
      end
    end
  end

  // State registers, updated only when a word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      goal_q   <= '0;
      head_q   <= DIR_STOP;
      driven_q <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      goal_q   <= goal_d;
      head_q   <= head_d;
      driven_q <= driven_d;
    end
  end

  // Status after the current word.
  always_comb begin
    stat_o.in1      = driven_d && heads_plus(head_d);
    stat_o.in2      = driven_d && heads_minus(head_d);
    stat_o.busy     = driven_d;
    stat_o.reached  = reached;
    stat_o.position = POS_OUT_W'($signed(pos_d));
  end

endmodule

// ===== rtl/wmec_outq.sv =====
// Two-entry result queue that lets a new word enter while a result waits.
// Depends on wmec_pkg for the result word type.
module wmec_outq
  import wmec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output result_t data_o
);

  result_t     entries_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entries_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/wheel_move_to_encoder_count_core.sv =====
// Top level of the wheel move controller: wheel units and result queue.
// Depends on wmec_pkg, wmec_in_if, wmec_out_if, wmec_wheel and wmec_outq.
//
//   Port    Dir   Word contents
//   in_i    sink  opcode, wheel, direction, pulse_target, phase_b
//   out_o   src   H-bridge pins, busy flags, positions, reached flags
//
// Each word is decoded and applied to the wheel state in the cycle it is taken,
// so one word per cycle is accepted while the result queue has room; its result
// is written into the two-entry result queue as the word is taken.
// Reset clears all positions, goals, headings and drive flags and empties the queue.
// When out_o stalls, in_i keeps taking words until two results are waiting.
module wheel_move_to_encoder_count_core
  import wmec_pkg::*;
#(
  parameter int WHEEL_COUNT   = 2,
  parameter int POSITION_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wmec_in_if.sink           in_i,
  wmec_out_if.source        out_o
);

  wheel_cmd_t  cmd;
  wheel_stat_t stat [WHEEL_COUNT];
  result_t     res_d, res_q;
  logic        accept, full, pop, out_valid;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && in_i.ready;

  // Command fields common to all wheels.
  always_comb begin
    cmd.opcode       = opcode_e'(in_i.opcode);
    cmd.direction    = in_i.direction;
    cmd.pulse_target = in_i.pulse_target;
    cmd.phase_b      = in_i.phase_b;
  end

  // One unit per wheel; only the first two can be addressed by a word.
  for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_wheel
    localparam bit Addressable = (i < 2);
    logic sel;

    assign sel = Addressable && (in_i.wheel == 1'(i % 2));

    wmec_wheel #(
      .POSITION_BITS(POSITION_BITS)
    ) u_wheel (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .accept_i(accept),
      .sel_i   (sel),
      .cmd_i   (cmd),
      .stat_o  (stat[i])
    );
  end

  // Right wheel result fields.
  always_comb begin
    res_d                = '0;
    res_d.right_in1      = stat[0].in1;
    res_d.right_in2      = stat[0].in2;
    res_d.right_busy     = stat[0].busy;
    res_d.right_position = stat[0].position;
    res_d.right_reached  = stat[0].reached;
  end

  // Left wheel result fields, zero when the left wheel is not built.
  result_t res_full;
  if (WHEEL_COUNT > 1) begin : g_left
    always_comb begin
      res_full               = res_d;
      res_full.left_in1      = stat[1].in1;
      res_full.left_in2      = stat[1].in2;
      res_full.left_busy     = stat[1].busy;
      res_full.left_position = stat[1].position;
      res_full.left_reached  = stat[1].reached;
    end
  end else begin : g_no_left
    assign res_full = res_d;
  end

  wmec_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (res_full),
    .full_o (full),
    .valid_o(out_valid),
    .pop_i  (pop),
    .data_o (res_q)
  );

  // Output channel.
  assign pop                  = out_valid && out_o.ready;
  assign out_o.valid          = out_valid;
  assign out_o.right_in1      = res_q.right_in1;
  assign out_o.right_in2      = res_q.right_in2;
  assign out_o.left_in1       = res_q.left_in1;
  assign out_o.left_in2       = res_q.left_in2;
  assign out_o.right_busy     = res_q.right_busy;
  assign out_o.left_busy      = res_q.left_busy;
  assign out_o.right_position = res_q.right_position;
  assign out_o.left_position  = res_q.left_position;
  assign out_o.right_reached  = res_q.right_reached;
  assign out_o.left_reached   = res_q.left_reached;

endmodule

// ===== rtl/wmec_checker.sv =====
// Port-level checks for the wheel move controller, bound to the top level.
// Depends on the top level's channel ports only.
module wmec_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic right_in1_i,
  input logic right_in2_i,
  input logic right_busy_i,
  input logic right_reached_i,
  input logic left_in1_i,
  input logic left_in2_i,
  input logic left_busy_i,
  input logic left_reached_i
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // After a taken word, a result is always offered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after an accepted word");

  // Busy matches exactly one driven bridge pin on each wheel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(right_in1_i && right_in2_i) && !(left_in1_i && left_in2_i) &&
                    (right_busy_i == (right_in1_i || right_in2_i)) &&
                    (left_busy_i == (left_in1_i || left_in2_i)))
    else $error("bridge pins disagree with busy flag");

  // A wheel stopped by its target is reported idle in the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (right_reached_i || left_reached_i) |->
      !(right_reached_i && right_busy_i) && !(left_reached_i && left_busy_i))
    else $error("reached wheel still busy");

endmodule

bind wheel_move_to_encoder_count_core wmec_checker u_wmec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .right_in1_i    (out_o.right_in1),
  .right_in2_i    (out_o.right_in2),
  .right_busy_i   (out_o.right_busy),
  .right_reached_i(out_o.right_reached),
  .left_in1_i     (out_o.left_in1),
  .left_in2_i     (out_o.left_in2),
  .left_busy_i    (out_o.left_busy),
  .left_reached_i (out_o.left_reached)
);

// ===== tb/wmec_tb_pkg.sv =====
`timescale 1ns / 1ps
// Testbench package for the wheel move controller: the command word type and the
// wheel state tracker that predicts and checks each result word. Depends on wmec_pkg.
package wmec_tb_pkg;
  import wmec_pkg::*;

  // Opcode and heading codes that the design package leaves unnamed.
  localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;
  localparam logic [DIR_W-1:0]    DIR_UNDEF_LO = 3'd5;
  localparam logic [DIR_W-1:0]    DIR_UNDEF_MID = 3'd6;
  localparam logic [DIR_W-1:0]    DIR_UNDEF_HI = 3'd7;

  // One command word as driven on the input channel.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                wheel;
    logic [DIR_W-1:0]    direction;
    logic [GOAL_W-1:0]   pulse_target;
    logic                phase_b;
  } cmd_word_t;

  // Tracks both wheels and keeps the status words that the design still owes.
  class wheel_state_tracker;
    logic [POS_OUT_W-1:0] position [2];
    logic [GOAL_W-1:0]    goal [2];
    logic [DIR_W-1:0]     heading [2];
    bit                   driven [2];
    result_t              expected_status [$];
    int                   errors;

    function new();
      for (int i = 0; i < 2; i++) begin
        position[i] = '0;
        goal[i]     = '0;
        heading[i]  = DIR_STOP;
        driven[i]   = 1'b0;
      end
      errors = 0;
    endfunction

    // +1 for headings that count up, -1 for those that count down, 0 otherwise.
    function int heading_step(logic [DIR_W-1:0] dir);
      case (dir)
        DIR_FWD, DIR_CW:   return 1;
        DIR_BACK, DIR_CCW: return -1;
        default:           return 0;
      endcase
    endfunction

    // Stops the wheel once a nonzero goal is met; true only if it was moving.
    function bit stop_at_goal(int w);
      logic [POS_OUT_W-1:0] mag;
      bit                   was;
      mag = position[w][POS_OUT_W-1] ? (~position[w] + POS_OUT_W'(1)) : position[w];
      if (goal[w] != '0 && mag >= {1'b0, goal[w]}) begin
        was       = driven[w];
        driven[w] = 1'b0;
        return was;
      end
      return 1'b0;
    endfunction

    // Applies one accepted command word and queues the status it should produce.
    function void note_word(cmd_word_t c);
      result_t r;
      bit      hit [2];
      int      step;
      hit[0] = 1'b0;
      hit[1] = 1'b0;
      case (c.opcode)
        OP_MOVE: begin
          heading[c.wheel]  = c.direction;
          goal[c.wheel]     = c.pulse_target;
          position[c.wheel] = '0;
          driven[c.wheel]   = (c.pulse_target != '0) && (heading_step(c.direction) != 0);
        end
        OP_EDGE: begin
          position[c.wheel] = c.phase_b ? position[c.wheel] - POS_OUT_W'(1)
                                        : position[c.wheel] + POS_OUT_W'(1);
          hit[c.wheel] = stop_at_goal(int'(c.wheel));
        end
        OP_TICK: begin
          for (int i = 0; i < 2; i++) begin
            step = heading_step(heading[i]);
            if (driven[i] && step != 0) begin
              position[i] = (step > 0) ? position[i] + POS_OUT_W'(1)
                                       : position[i] - POS_OUT_W'(1);
              hit[i] = stop_at_goal(i);
            end
          end
        end
        default: ;
      endcase

      r.right_in1      = driven[0] && heading_step(heading[0]) > 0;
      r.right_in2      = driven[0] && heading_step(heading[0]) < 0;
      r.left_in1       = driven[1] && heading_step(heading[1]) > 0;
      r.left_in2       = driven[1] && heading_step(heading[1]) < 0;
      r.right_busy     = driven[0];
      r.left_busy      = driven[1];
      r.right_position = position[0];
      r.left_position  = position[1];
      r.right_reached  = hit[0];
      r.left_reached   = hit[1];
      expected_status.push_back(r);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result word with the oldest expected status.
    function void check_status(result_t got);
      result_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: result word with nothing expected: got %h", $time, got);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("right_in1", want.right_in1, got.right_in1);
      compare_field("right_in2", want.right_in2, got.right_in2);
      compare_field("left_in1", want.left_in1, got.left_in1);
      compare_field("left_in2", want.left_in2, got.left_in2);
      compare_field("right_busy", want.right_busy, got.right_busy);
      compare_field("left_busy", want.left_busy, got.left_busy);
      compare_field("right_position", want.right_position, got.right_position);
      compare_field("left_position", want.left_position, got.left_position);
      compare_field("right_reached", want.right_reached, got.right_reached);
      compare_field("left_reached", want.left_reached, got.left_reached);
    endfunction

    // Any status still owed at the end is a failure.
    function void report_leftovers();
      if (expected_status.size() != 0) begin
        $display("%0t: %0d expected result words never arrived", $time,
                 expected_status.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the wheel move controller testbench: clock, reset, word drivers and checks.
// Depends on wmec_pkg, wmec_in_if, wmec_out_if, wmec_tb_pkg and the core itself.
module tb;
  import wmec_pkg::*;
  import wmec_tb_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   cycles;

  wheel_state_tracker tracker;

  wmec_in_if  in_bus ();
  wmec_out_if out_bus ();

  wheel_move_to_encoder_count_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter that ends a hung run.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, tracker.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: ready changes at the falling edge, idling at the current rate.
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result words are checked at the rising edge where they are taken.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.right_in1      = out_bus.right_in1;
      got.right_in2      = out_bus.right_in2;
      got.left_in1       = out_bus.left_in1;
      got.left_in2       = out_bus.left_in2;
      got.right_busy     = out_bus.right_busy;
      got.left_busy      = out_bus.left_busy;
      got.right_position = out_bus.right_position;
      got.left_position  = out_bus.left_position;
      got.right_reached  = out_bus.right_reached;
      got.left_reached   = out_bus.left_reached;
      tracker.check_status(got);
    end
  end

  // Drives one command word and waits until the core takes it.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic w,
                           input logic [DIR_W-1:0] dir, input logic [GOAL_W-1:0] tgt,
                           input logic pb);
    cmd_word_t c;
    c.opcode       = op;
    c.wheel        = w;
    c.direction    = dir;
    c.pulse_target = tgt;
    c.phase_b      = pb;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= c.opcode;
    in_bus.wheel        <= c.wheel;
    in_bus.direction    <= c.direction;
    in_bus.pulse_target <= c.pulse_target;
    in_bus.phase_b      <= c.phase_b;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.note_word(c);
    if (op != OP_UNUSED) words_sent++;
  endtask

  // A tick with the fields it ignores filled at random.
  task automatic send_tick();
    send_word(OP_TICK, 1'($urandom_range(0, 1)), DIR_W'($urandom_range(0, 7)),
              GOAL_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // A move command followed by a run of edges and ticks that usually hits its goal.
  task automatic send_move_run();
    logic             w;
    logic [DIR_W-1:0] dir;
    logic [GOAL_W-1:0] tgt;
    int               sel;
    int               len;
    bit               down;
    w   = 1'($urandom_range(0, 1));
    dir = ($urandom_range(0, 9) < 8) ? DIR_W'($urandom_range(1, 4))
                                     : DIR_W'($urandom_range(0, 7));
    sel = $urandom_range(0, 9);
    tgt = (sel == 0) ? '0 : (sel == 1) ? GOAL_W'($urandom)
                                       : GOAL_W'($urandom_range(1, 12));
    down = (dir == DIR_BACK) || (dir == DIR_CCW);
    send_word(OP_MOVE, w, dir, tgt, 1'($urandom_range(0, 1)));
    len = $urandom_range(1, 16);
    repeat (len) begin
      if ($urandom_range(0, 1) == 0) begin
        send_tick();
      end else begin
        send_word(OP_EDGE, ($urandom_range(0, 7) == 0) ? ~w : w,
                  DIR_W'($urandom_range(0, 7)), GOAL_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : down);
      end
    end
  endtask

  // Stimulus: directed cases, then three random phases with different idling.
  initial begin
    int drain;
    tracker             = new();
    words_sent          = 0;
    send_idle_pct       = 28;
    recv_idle_pct       = 74;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = OP_MOVE;
    in_bus.wheel        = 1'b0;
    in_bus.direction    = DIR_STOP;
    in_bus.pulse_target = '0;
    in_bus.phase_b      = 1'b0;
    rst_ni              = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle state after reset, and the unused opcode.
    send_word(OP_TICK, 1'b0, DIR_STOP, '0, 1'b0);
    send_word(OP_UNUSED, 1'b1, DIR_UNDEF_HI, '1, 1'b1);
    // Right wheel runs forward on ticks until its goal stops it.
    send_word(OP_MOVE, 1'b0, DIR_FWD, 31'd3, 1'b0);
    repeat (3) send_word(OP_TICK, 1'b0, DIR_STOP, '0, 1'b0);
    // Left wheel runs backward on encoder edges.
    send_word(OP_MOVE, 1'b1, DIR_BACK, 31'd2, 1'b0);
    repeat (2) send_word(OP_EDGE, 1'b1, DIR_STOP, '0, 1'b1);
    // Both wheels rotate; the left one stops on its first tick.
    send_word(OP_MOVE, 1'b0, DIR_CW, '1, 1'b1);
    send_word(OP_MOVE, 1'b1, DIR_CCW, 31'd1, 1'b1);
    send_tick();
    // Counting through zero keeps the right wheel moving.
    repeat (2) send_word(OP_EDGE, 1'b0, DIR_STOP, '0, 1'b1);
    // Undefined headings and the stop heading leave the wheel undriven.
    send_word(OP_MOVE, 1'b0, DIR_UNDEF_LO, 31'd5, 1'b0);
    send_tick();
    send_word(OP_MOVE, 1'b1, DIR_UNDEF_HI, 31'd4, 1'b0);
    send_word(OP_MOVE, 1'b0, DIR_STOP, 31'd1, 1'b0);
    // An edge that meets the goal of an idle wheel reports no stop.
    send_word(OP_EDGE, 1'b0, DIR_STOP, '0, 1'b0);
    // A zero goal does not drive the wheel.
    send_word(OP_MOVE, 1'b1, DIR_FWD, '0, 1'b0);
    send_word(OP_EDGE, 1'b1, DIR_STOP, '0, 1'b0);
    send_word(OP_MOVE, 1'b0, DIR_UNDEF_MID, '1, 1'b0);
    send_word(OP_MOVE, 1'b1, DIR_BACK, '1, 1'b0);
    send_tick();
    send_word(OP_EDGE, 1'b1, DIR_STOP, '0, 1'b0);

    // Random phases: mostly move runs, some words with every field random.
    words_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 28 : 0;
      while (words_sent < (phase + 1) * RANDOM_WORDS / 3) begin
        if ($urandom_range(0, 3) != 0) begin
          send_move_run();
        end else begin
          send_word(OPCODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    DIR_W'($urandom_range(0, 7)),
                    ($urandom_range(0, 1) == 0) ? GOAL_W'($urandom_range(0, 15))
                                                : GOAL_W'($urandom),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    // Drain the outstanding results, then let the clock run on before the report.
    drain = 0;
    while (tracker.pending() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    tracker.report_leftovers();
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
